[design/button_multi_click_detector_macros.svh]
// Assertion macros shared by the click detector RTL.
// Every check is clocked on clk_i and disabled while rst_ni is low.
`ifndef BUTTON_MULTI_CLICK_DETECTOR_MACROS_SVH
`define BUTTON_MULTI_CLICK_DETECTOR_MACROS_SVH

// Clocked check with an explicit clock and reset.
`define BMCD_ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("button_multi_click_detector check failed");

// Clocked check on the default clock and reset of this block.
`define BMCD_ASSERT(label, prop) \
  `BMCD_ASSERT_CLK(label, clk_i, rst_ni, prop)

`endif

[design/bmcd_pkg.sv]
// Package for the button multi-click detector: widths, reset values,
// configuration register indexes and stream payload layout. No dependencies.
package bmcd_pkg;

  // Width of the tick counter and of the stored onset times.
  localparam int unsigned TIME_WIDTH   = 32;
  localparam int unsigned ID_WIDTH     = 32;
  localparam int unsigned WINDOW_WIDTH = 16;

  // Configuration port.
  localparam int unsigned CFG_IDX_WIDTH = 8;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_DOUBLE_WINDOW = 8'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_TRIPLE_WINDOW = 8'd1;

  localparam logic [WINDOW_WIDTH-1:0] DOUBLE_WINDOW_RESET = 16'd300;
  localparam logic [WINDOW_WIDTH-1:0] TRIPLE_WINDOW_RESET = 16'd700;

  // Reserved press id that means "no valid press".
  localparam logic [ID_WIDTH-1:0] ID_INVALID = '1;

  // Stream payload widths, rounded up to whole bytes.
  localparam int unsigned IN_DATA_WIDTH  = 8;
  localparam int unsigned RES_BITS       = 7 + 2 * ID_WIDTH;
  localparam int unsigned OUT_DATA_WIDTH = ((RES_BITS + 7) / 8) * 8;

  // One result item.
  typedef struct packed {
    logic [ID_WIDTH-1:0] hold_ticks;
    logic [ID_WIDTH-1:0] press_number;
    logic                triple_click_release;
    logic                double_click_release;
    logic                triple_click;
    logic                double_click;
    logic                release_res;
    logic                onset;
    logic                level;
  } result_t;

endpackage

[design/button_multi_click_detector.sv]
// Button multi-click detector top level.
// Path: an item passes through the input register and then the result register.
// Throughput: one item per cycle; the input register and the result register
// advance together, so the only stall source is m_axis_tready.
// Reset (rst_ni low, asynchronous): tick and onset history cleared, press id and
// stored click ids all ones, windows 300 and 700 ticks, both channels empty.
module button_multi_click_detector (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration write channel.
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [bmcd_pkg::CFG_IDX_WIDTH-1:0]   cfg_index_i,
  input  logic [bmcd_pkg::WINDOW_WIDTH-1:0]    cfg_data_i,
  // Input stream.
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata from bit 0: pressed_now, clear_history, zero padding.
  input  logic [bmcd_pkg::IN_DATA_WIDTH-1:0]   s_axis_tdata,
  // Result stream.
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // tdata from bit 0: level, onset, release_res, double_click, triple_click,
  // double_click_release, triple_click_release, press_number[31:0],
  // hold_ticks[31:0], zero padding.
  output logic [bmcd_pkg::OUT_DATA_WIDTH-1:0]  m_axis_tdata
);
  import bmcd_pkg::*;

  // Configuration registers.
  logic [WINDOW_WIDTH-1:0] dbl_window_q, trp_window_q;

  // Input register.
  logic in_valid_q, in_valid_d;
  logic in_pressed_q, in_clear_q;

  // Detector state.
  logic [TIME_WIDTH-1:0] tick_q, tick_d;
  logic [TIME_WIDTH-1:0] last_onset_q, last_onset_d;
  logic [TIME_WIDTH-1:0] prev_onset_q, prev_onset_d;
  logic                  prev_level_q;
  logic [ID_WIDTH-1:0]   press_q, press_d;
  logic [ID_WIDTH-1:0]   hold_q, hold_d;
  logic [ID_WIDTH-1:0]   dbl_id_q, dbl_id_d;
  logic [ID_WIDTH-1:0]   trp_id_q, trp_id_d;

  // Result register.
  logic    out_valid_q, out_valid_d;
  result_t res_q, res_d;

  logic in_xfer, advance;

  // Handshake: the stage moves when it holds an item and the result slot frees.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign in_valid_d    = in_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d   = advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);
  assign cfg_ready_o   = 1'b1;

  // Click evaluation for the item in the input register.
  logic                  onset, rel;
  logic                  trp_hit, dbl_hit;
  logic [TIME_WIDTH-1:0] trp_age, dbl_age;
  logic [ID_WIDTH-1:0]   press_inc;

  always_comb begin
    onset     = in_pressed_q && !prev_level_q;
    rel       = prev_level_q && !in_pressed_q;
    trp_age   = tick_q - prev_onset_q;
    dbl_age   = tick_q - last_onset_q;
    trp_hit   = trp_age < TIME_WIDTH'(trp_window_q);
    dbl_hit   = !trp_hit && (dbl_age < TIME_WIDTH'(dbl_window_q));
    press_inc = press_q + ID_WIDTH'(1);

    press_d      = press_q;
    dbl_id_d     = dbl_id_q;
    trp_id_d     = trp_id_q;
    last_onset_d = last_onset_q;
    prev_onset_d = prev_onset_q;

    res_d        = '0;
    res_d.level  = in_pressed_q;
    res_d.onset  = onset;
    res_d.release_res = rel;

    if (onset) begin
      // Skip the reserved id when the counter wraps onto it.
      press_d = (press_inc == ID_INVALID) ? '0 : press_inc;
      if (trp_hit) begin
        res_d.triple_click = 1'b1;
        trp_id_d = press_d;
      end else if (dbl_hit) begin
        res_d.double_click = 1'b1;
        dbl_id_d = press_d;
      end
      prev_onset_d = last_onset_q;
      last_onset_d = tick_q;
    end

    // A release matches the press id that was flagged; triple wins a tie.
    if (rel) begin
      if (press_q == trp_id_q) begin
        res_d.triple_click_release = 1'b1;
      end else if (press_q == dbl_id_q) begin
        res_d.double_click_release = 1'b1;
      end
    end

    // Hold time counts the onset tick as one and saturates.
    if (!in_pressed_q) begin
      hold_d = '0;
    end else if (onset) begin
      hold_d = ID_WIDTH'(1);
    end else if (hold_q != '1) begin
      hold_d = hold_q + ID_WIDTH'(1);
    end else begin
      hold_d = hold_q;
    end

    tick_d = tick_q + TIME_WIDTH'(1);

    // Clearing the history wins over this tick's onset bookkeeping.
    if (in_clear_q) begin
      last_onset_d = '0;
      prev_onset_d = '0;
    end

    res_d.press_number = press_d;
    res_d.hold_ticks   = hold_d;
  end

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbl_window_q <= DOUBLE_WINDOW_RESET;
      trp_window_q <= TRIPLE_WINDOW_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_DOUBLE_WINDOW: dbl_window_q <= cfg_data_i;
        CFG_TRIPLE_WINDOW: trp_window_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Control and detector state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      tick_q       <= '0;
      last_onset_q <= '0;
      prev_onset_q <= '0;
      prev_level_q <= 1'b0;
      press_q      <= ID_INVALID;
      hold_q       <= '0;
      dbl_id_q     <= ID_INVALID;
      trp_id_q     <= ID_INVALID;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        tick_q       <= tick_d;
        last_onset_q <= last_onset_d;
        prev_onset_q <= prev_onset_d;
        prev_level_q <= in_pressed_q;
        press_q      <= press_d;
        hold_q       <= hold_d;
        dbl_id_q     <= dbl_id_d;
        trp_id_q     <= trp_id_d;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_pressed_q <= s_axis_tdata[0];
      in_clear_q   <= s_axis_tdata[1];
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_WIDTH'(res_q);

`include "button_multi_click_detector_macros.svh"

  // An edge is either an onset or a release, never both.
  `BMCD_ASSERT(a_edge_excl, out_valid_q |-> !(res_q.onset && res_q.release_res))
  // Click flags come only with an onset, and at most one of them.
  `BMCD_ASSERT(a_click_on_onset,
      out_valid_q && (res_q.double_click || res_q.triple_click) |->
      res_q.onset && !(res_q.double_click && res_q.triple_click))
  // A press that has begun never carries the reserved id.
  `BMCD_ASSERT(a_id_valid, out_valid_q && res_q.onset |-> res_q.press_number != ID_INVALID)
  // The hold count is nonzero exactly while the button is down.
  `BMCD_ASSERT(a_hold_level, out_valid_q |-> (res_q.level == (res_q.hold_ticks != '0)))
  // Time only moves when an item is processed.
  `BMCD_ASSERT(a_tick_hold, !advance |=> $stable(tick_q))

endmodule

[tb/tb_button_multi_click_detector.sv]
// Self-checking testbench for button_multi_click_detector.
// Depends on bmcd_pkg and the design. It drives the sample stream and the
// window registers, predicts each result in a scoreboard and checks it field by field.
module tb_button_multi_click_detector;
  import bmcd_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 1000000;
  localparam int unsigned ITEMS_PER_PHASE = 340;
  localparam int unsigned MAX_REPORTS     = 10;

  typedef logic [TIME_WIDTH-1:0]   tick_t;
  typedef logic [ID_WIDTH-1:0]     press_id_t;
  typedef logic [WINDOW_WIDTH-1:0] window_t;

  // Scoreboard: tracks the click history and queues the expected per-tick reports.
  class click_scoreboard;
    tick_t       now_tick, last_onset, prior_onset;
    bit          was_pressed;
    press_id_t   press_id, held, double_id, triple_id;
    window_t     double_win, triple_win;
    result_t     expected_reports[$];
    int unsigned mismatches, checked;

    function new();
      now_tick    = '0;
      last_onset  = '0;
      prior_onset = '0;
      was_pressed = 1'b0;
      press_id    = ID_INVALID;
      held        = '0;
      double_id   = ID_INVALID;
      triple_id   = ID_INVALID;
      double_win  = DOUBLE_WINDOW_RESET;
      triple_win  = TRIPLE_WINDOW_RESET;
      mismatches  = 0;
      checked     = 0;
    endfunction

    function void write_window(logic [CFG_IDX_WIDTH-1:0] idx, window_t value);
      if (idx == CFG_DOUBLE_WINDOW) begin
        double_win = value;
      end else if (idx == CFG_TRIPLE_WINDOW) begin
        triple_win = value;
      end
    endfunction

    // Advance the click history by one accepted sample and queue its report.
    function void note_sample(bit pressed, bit clear_hist);
      result_t report;
      tick_t   since_prior, since_last;
      report             = '0;
      report.level       = pressed;
      report.onset       = pressed && !was_pressed;
      report.release_res = was_pressed && !pressed;
      if (report.onset) begin
        press_id = press_id + 1'b1;
        if (press_id == ID_INVALID) begin
          press_id = '0;
        end
        held        = '0;
        since_prior = now_tick - prior_onset;
        since_last  = now_tick - last_onset;
        // The triple check takes precedence over the double check.
        if (since_prior < tick_t'(triple_win)) begin
          report.triple_click = 1'b1;
          triple_id           = press_id;
        end else if (since_last < tick_t'(double_win)) begin
          report.double_click = 1'b1;
          double_id           = press_id;
        end
        prior_onset = last_onset;
        last_onset  = now_tick;
      end
      if (report.release_res) begin
        if (press_id == triple_id) begin
          report.triple_click_release = 1'b1;
        end else if (press_id == double_id) begin
          report.double_click_release = 1'b1;
        end
      end
      // Hold time saturates instead of wrapping.
      if (pressed) begin
        if (held != '1) begin
          held = held + 1'b1;
        end
      end else begin
        held = '0;
      end
      was_pressed = pressed;
      now_tick    = now_tick + 1'b1;
      if (clear_hist) begin
        last_onset  = '0;
        prior_onset = '0;
      end
      report.press_number = press_id;
      report.hold_ticks   = held;
      expected_reports.push_back(report);
    endfunction

    function int unsigned pending();
      return expected_reports.size();
    endfunction

    function void compare_field(string field, logic [ID_WIDTH-1:0] want,
                                logic [ID_WIDTH-1:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("result %0d, %s: expected %0h, got %0h", checked, field, want, got);
        end
      end
    endfunction

    // Compare one result transfer against the oldest queued report.
    function void check_result(result_t got);
      result_t want;
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("result with nothing queued: %0h", got);
        end
        return;
      end
      want = expected_reports.pop_front();
      compare_field("level", want.level, got.level);
      compare_field("onset", want.onset, got.onset);
      compare_field("release_res", want.release_res, got.release_res);
      compare_field("double_click", want.double_click, got.double_click);
      compare_field("triple_click", want.triple_click, got.triple_click);
      compare_field("double_click_release", want.double_click_release,
                    got.double_click_release);
      compare_field("triple_click_release", want.triple_click_release,
                    got.triple_click_release);
      compare_field("press_number", want.press_number, got.press_number);
      compare_field("hold_ticks", want.hold_ticks, got.hold_ticks);
      checked++;
    endfunction
  endclass

  logic                      clk_i         = 1'b0;
  logic                      rst_ni        = 1'b0;
  logic                      cfg_valid_i   = 1'b0;
  logic                      cfg_ready_o;
  logic [CFG_IDX_WIDTH-1:0]  cfg_index_i   = '0;
  logic [WINDOW_WIDTH-1:0]   cfg_data_i    = '0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [IN_DATA_WIDTH-1:0]  s_axis_tdata  = '0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [OUT_DATA_WIDTH-1:0] m_axis_tdata;

  click_scoreboard board = new();
  int unsigned     sent_items = 0;
  int unsigned     phase_end  = 0;
  int unsigned     cycles     = 0;
  bit              idle_gaps  = 1'b0;

  button_multi_click_detector uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Idle length before a sample: mostly none, some short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic bit rare_clear();
    return $urandom_range(0, 99) < 3;
  endfunction

  // Offer one sample and wait for its transfer.
  task automatic send_sample(bit pressed, bit clear_hist);
    int unsigned              gap;
    logic [IN_DATA_WIDTH-1:0] word;
    gap     = idle_gaps ? pick_gap() : 0;
    word    = '0;
    word[0] = pressed;
    word[1] = clear_hist;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    @(posedge clk_i);
    while (!(s_axis_tvalid && s_axis_tready)) @(posedge clk_i);
    board.note_sample(pressed, clear_hist);
    sent_items++;
  endtask

  // Hold one level for n samples; the samples stop once the phase is full.
  task automatic hold_level(bit lvl, int unsigned n);
    repeat (n) begin
      if (sent_items < phase_end) begin
        send_sample(lvl, rare_clear());
      end
    end
  endtask

  // A burst of one to four clicks with gaps that sometimes sit near a window edge.
  task automatic run_click_burst();
    int unsigned clicks, press_len, roll;
    int          gap;
    window_t     edge_win;
    idle_gaps = ($urandom_range(0, 3) != 0);
    clicks    = $urandom_range(1, 4);
    repeat (clicks) begin
      roll = $urandom_range(0, 99);
      if (roll < 85) begin
        press_len = $urandom_range(1, 4);
      end else if (roll < 95) begin
        press_len = $urandom_range(5, 30);
      end else begin
        press_len = $urandom_range(100, 400);
      end
      hold_level(1'b1, press_len);
      roll     = $urandom_range(0, 99);
      edge_win = roll[0] ? board.double_win : board.triple_win;
      if (roll < 75 || (roll < 90 && edge_win > 900)) begin
        gap = $urandom_range(1, 25);
      end else if (roll < 90) begin
        // Put the next onset one tick before, at, or after the window edge.
        gap = int'(edge_win) - int'(press_len) + int'($urandom_range(0, 2)) - 1;
        if (gap < 1) gap = 1;
      end else begin
        gap = $urandom_range(50, 800);
      end
      hold_level(1'b0, gap);
    end
  endtask

  task automatic run_noise();
    idle_gaps = 1'b1;
    repeat ($urandom_range(1, 10)) begin
      send_sample(bit'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
    end
  endtask

  // Stop offering samples and wait until every queued report has arrived.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  task automatic run_phase();
    int unsigned start;
    start     = sent_items;
    phase_end = start + ITEMS_PER_PHASE;
    while (sent_items - start < ITEMS_PER_PHASE) begin
      if ($urandom_range(0, 99) < 15) begin
        run_noise();
      end else begin
        run_click_burst();
      end
    end
    settle();
  endtask

  // Write one window register; valid stays high for a following write.
  task automatic write_reg(logic [CFG_IDX_WIDTH-1:0] idx, window_t value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!(cfg_valid_i && cfg_ready_o)) @(posedge clk_i);
    board.write_window(idx, value);
  endtask

  task automatic set_windows(window_t dbl, window_t trp);
    write_reg(CFG_DOUBLE_WINDOW, dbl);
    write_reg(CFG_TRIPLE_WINDOW, trp);
    cfg_valid_i <= 1'b0;
  endtask

  // Main sequence: directed samples, then random phases over several window settings.
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // First press right after reset reads as a triple click.
    send_sample(1'b1, 1'b0);
    send_sample(1'b1, 1'b0);
    send_sample(1'b0, 1'b0);
    // Clear while released, then clear on an onset tick.
    send_sample(1'b0, 1'b1);
    send_sample(1'b1, 1'b1);
    send_sample(1'b1, 1'b0);
    send_sample(1'b0, 1'b0);
    // Onset against a freshly cleared history.
    send_sample(1'b1, 1'b0);
    send_sample(1'b0, 1'b1);
    send_sample(1'b0, 1'b0);
    send_sample(1'b1, 1'b0);
    send_sample(1'b0, 1'b0);
    settle();

    run_phase();
    set_windows(16'd1, 16'd1);
    run_phase();
    set_windows('1, '1);
    run_phase();
    set_windows(16'd20, 16'd60);
    run_phase();
    set_windows(16'd300, 16'd100);
    run_phase();
    set_windows(window_t'($urandom_range(1, 500)), window_t'($urandom_range(1, 1000)));
    run_phase();

    // Let any stray result show up before the verdict.
    repeat (8) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Result side: ready runs of mixed length with mostly short stalls.
  initial begin
    int unsigned roll;
    @(posedge rst_ni);
    forever begin
      m_axis_tready <= 1'b1;
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end else if (roll < 95) begin
        repeat ($urandom_range(20, 100)) @(posedge clk_i);
      end else begin
        repeat ($urandom_range(200, 400)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b0;
      if ($urandom_range(0, 99) < 85) begin
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end else begin
        repeat ($urandom_range(10, 50)) @(posedge clk_i);
      end
    end
  end

  // Check every result transfer.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      board.check_result(result_t'(m_axis_tdata[$bits(result_t)-1:0]));
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule

[files.f]
+incdir+design
design/bmcd_pkg.sv
design/button_multi_click_detector.sv
tb/tb_button_multi_click_detector.sv
